// ===== design/assert_macros.svh =====
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mmp_pkg.sv =====
`timescale 1ns / 1ps

package mmp_pkg;

  // Status byte codes
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_SYS_RESET   = 8'hFF;
  localparam logic [4:0] RT_PREFIX      = 5'h1F;  // top bits of F8..FF

  // Upper nibble of a status byte
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_PROGRAM  = 4'hC;
  localparam logic [3:0] KIND_PRESSURE = 4'hD;
  localparam logic [3:0] KIND_SYSTEM   = 4'hF;

  localparam logic [1:0] LEN_ONE = 2'd1;
  localparam logic [1:0] LEN_TWO = 2'd2;

  // One assembled channel message
  typedef struct packed {
    logic [1:0] msg_length;
    logic [6:0] second_data;
    logic [6:0] first_data;
    logic [7:0] msg_status;
  } mmp_msg_t;

endpackage

// ===== design/midi_message_parser.sv =====
`timescale 1ns / 1ps

// Channel   Dir  tdata fields (low bit up)
// in_       in   in_byte[7:0]
// out_      out  msg_status[7:0], first_data[14:8], second_data[21:15], msg_length[23:22]
//
// One item per cycle sustained while out_ does not stall; a byte is parsed from the input register
// once it is taken and out_ has room, and its result is registered in the output register
// and offered on out_. Bytes that complete no message are absorbed without output.
// Synchronous active-low reset clears running status, counts and SysEx state.
// A stall on out_ backs up through the output register to in_tready.
module midi_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // msg_status, first_data, second_data, msg_length
);

  logic              byte_valid;
  logic [7:0]        byte_data;
  logic              out_free;
  logic              step;
  logic              res_valid;
  mmp_pkg::mmp_msg_t res_msg;

  assign step = byte_valid && out_free;

  mmp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .consume    (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  mmp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_data (byte_data),
    .res_valid (res_valid),
    .res_msg   (res_msg)
  );

  mmp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_msg    (res_msg),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== design/mmp_in_reg.sv =====
`timescale 1ns / 1ps

module mmp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       consume,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // Take a new item when empty or when the held one is used this cycle
  assign in_tready = !valid_r || consume;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

// ===== design/mmp_parse.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmp_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       byte_data,
  output logic             res_valid,
  output mmp_pkg::mmp_msg_t res_msg
);

  logic [7:0] rs_r, rs_nxt;        // running status, zero when none
  logic       half_r, half_nxt;    // first data byte held
  logic       two_r, two_nxt;      // message expects two data bytes
  logic       sysex_r, sysex_nxt;
  logic [6:0] held_r, held_nxt;

  logic       is_rt;
  logic       is_sys;
  logic [6:0] d1;
  logic [6:0] d2;

  assign is_rt  = (byte_data[7:3] == mmp_pkg::RT_PREFIX);
  assign is_sys = (byte_data[7:4] == mmp_pkg::KIND_SYSTEM);

  // Next state and result
  always_comb begin
    rs_nxt    = rs_r;
    half_nxt  = half_r;
    two_nxt   = two_r;
    sysex_nxt = sysex_r;
    held_nxt  = held_r;
    res_valid = 1'b0;
    if (step) begin
      if (is_rt) begin
        if (byte_data == mmp_pkg::ST_SYS_RESET) begin
          rs_nxt   = 8'h00;
          half_nxt = 1'b0;
        end
      end else if (is_sys) begin
        if (byte_data == mmp_pkg::ST_SYSEX_START) begin
          sysex_nxt = 1'b1;
        end else if (byte_data == mmp_pkg::ST_SYSEX_END) begin
          sysex_nxt = 1'b0;
        end
        rs_nxt   = 8'h00;
        half_nxt = 1'b0;
      end else if (sysex_r) begin
        // SysEx payload dropped
      end else if (byte_data[7]) begin
        rs_nxt   = byte_data;
        half_nxt = 1'b0;
        two_nxt  = !(byte_data[7:4] == mmp_pkg::KIND_PROGRAM ||
                     byte_data[7:4] == mmp_pkg::KIND_PRESSURE);
      end else if (rs_r[7]) begin
        if (!half_r && two_r) begin
          held_nxt = byte_data[6:0];
          half_nxt = 1'b1;
        end else begin
          res_valid = 1'b1;
          half_nxt  = 1'b0;
        end
      end
    end
  end

  // Message fields; a one-byte message carries zero as second data
  assign d1 = half_r ? held_r : byte_data[6:0];
  assign d2 = half_r ? byte_data[6:0] : 7'd0;

  always_comb begin
    res_msg.msg_status  = rs_r;
    res_msg.first_data  = d1;
    res_msg.second_data = d2;
    res_msg.msg_length  = two_r ? mmp_pkg::LEN_TWO : mmp_pkg::LEN_ONE;
    // Note On with zero velocity becomes Note Off
    if (rs_r[7:4] == mmp_pkg::KIND_NOTE_ON && two_r && d2 == 7'd0) begin
      res_msg.msg_status = {mmp_pkg::KIND_NOTE_OFF, rs_r[3:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r    <= 8'h00;
      half_r  <= 1'b0;
      two_r   <= 1'b0;
      sysex_r <= 1'b0;
    end else begin
      rs_r    <= rs_nxt;
      half_r  <= half_nxt;
      two_r   <= two_nxt;
      sysex_r <= sysex_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  `ASSERT_CLK(a_res_channel_status, clk, rst_n, !res_valid || (res_msg.msg_status[7] && res_msg.msg_status[7:4] != mmp_pkg::KIND_SYSTEM), "result status is not a channel voice byte")
  `ASSERT_CLK(a_no_result_in_sysex, clk, rst_n, !(res_valid && sysex_r), "result emitted inside SysEx")
  `ASSERT_CLK(a_half_needs_status, clk, rst_n, !half_r || (rs_r[7] && two_r), "held data byte without two-byte running status")

endmodule

// ===== design/mmp_out_reg.sv =====
`timescale 1ns / 1ps

module mmp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  mmp_pkg::mmp_msg_t res_msg,
  output logic              out_free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata
);

  logic              valid_r;
  logic              valid_nxt;
  mmp_pkg::mmp_msg_t msg_r;

  // Free when empty or the held item leaves this cycle
  assign out_free  = !valid_r || out_tready;
  assign valid_nxt = res_valid ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      msg_r <= res_msg;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = msg_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int N_ITEMS      = 1050;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES = 10;    // drain margin after the last expected message
  localparam int MAX_REPORTS  = 10;

  // Expected-message tracker: mirrors the parser state and checks out_ items
  class midi_scoreboard;
    logic [7:0]        run_status = '0;
    logic [1:0]        collected  = '0;
    logic [1:0]        exp_len    = '0;
    bit                sysex_open = 1'b0;
    logic [6:0]        held_data  = '0;
    mmp_pkg::mmp_msg_t expected_q[$];
    int                errors     = 0;

    function void flag(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR: %s", what);
    endfunction

    // Update parser state for one accepted byte; queue a message if it completes one
    function void note_input(logic [7:0] b);
      mmp_pkg::mmp_msg_t msg;
      // real-time: only system reset has an effect
      if (b[7:3] == mmp_pkg::RT_PREFIX) begin
        if (b == mmp_pkg::ST_SYS_RESET) begin
          run_status = '0;
          collected  = '0;
        end
        return;
      end
      // system common: SysEx bracket, always drops running status
      if (b[7:4] == mmp_pkg::KIND_SYSTEM) begin
        if (b == mmp_pkg::ST_SYSEX_START) sysex_open = 1'b1;
        else if (b == mmp_pkg::ST_SYSEX_END) sysex_open = 1'b0;
        run_status = '0;
        collected  = '0;
        return;
      end
      if (sysex_open) return;
      // channel voice status
      if (b[7]) begin
        run_status = b;
        collected  = '0;
        exp_len    = (b[7:4] == mmp_pkg::KIND_PROGRAM || b[7:4] == mmp_pkg::KIND_PRESSURE) ?
                     mmp_pkg::LEN_ONE : mmp_pkg::LEN_TWO;
        return;
      end
      // data byte
      if (run_status == '0) return;
      if (collected == 2'd0 && exp_len >= mmp_pkg::LEN_TWO) begin
        held_data = b[6:0];
        collected = 2'd1;
        return;
      end
      if (collected == 2'd0) begin
        msg.first_data  = b[6:0];
        msg.second_data = '0;
      end else begin
        msg.first_data  = held_data;
        msg.second_data = b[6:0];
      end
      collected = '0;
      msg.msg_status = run_status;
      // note on with zero velocity is a note off
      if (run_status[7:4] == mmp_pkg::KIND_NOTE_ON && exp_len >= mmp_pkg::LEN_TWO &&
          msg.second_data == '0)
        msg.msg_status = {mmp_pkg::KIND_NOTE_OFF, run_status[3:0]};
      msg.msg_length = exp_len;
      expected_q.push_back(msg);
    endfunction

    function void check_result(logic [23:0] data);
      mmp_pkg::mmp_msg_t got;
      mmp_pkg::mmp_msg_t want;
      got = mmp_pkg::mmp_msg_t'(data);
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected message %h", data));
        return;
      end
      want = expected_q.pop_front();
      if (got.msg_status !== want.msg_status)
        flag($sformatf("msg_status expected %h got %h", want.msg_status, got.msg_status));
      if (got.first_data !== want.first_data)
        flag($sformatf("first_data expected %h got %h", want.first_data, got.first_data));
      if (got.second_data !== want.second_data)
        flag($sformatf("second_data expected %h got %h", want.second_data, got.second_data));
      if (got.msg_length !== want.msg_length)
        flag($sformatf("msg_length expected %0d got %0d", want.msg_length, got.msg_length));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  midi_scoreboard sb = new;
  bit steady      = 1'b0;  // when set, neither side idles
  int bytes_sent  = 0;
  int idle_cycles = 0;

  midi_message_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] rand_data();
    // zero often enough to hit zero-velocity note on
    return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 127));
  endfunction

  // Result side: random stalls between items
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Result checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog on a stalled pipe
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int pick;
    int n_msgs;
    int n_bytes;
    logic [7:0] status;
    logic [1:0] len;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // orphan data before any status
    send_byte(8'h7F);
    // note off, top channel, data extremes
    send_byte({mmp_pkg::KIND_NOTE_OFF, 4'hF}); send_byte(8'h00); send_byte(8'h7F);
    // note on with zero velocity, then running status
    send_byte({mmp_pkg::KIND_NOTE_ON, 4'h0}); send_byte(8'h3C); send_byte(8'h00);
    send_byte(8'h3C); send_byte(8'h7F);
    // poly pressure with real-time bytes inside the message
    send_byte(8'hA1); send_byte({mmp_pkg::RT_PREFIX, 3'd0}); send_byte(8'h40);
    send_byte({mmp_pkg::RT_PREFIX, 3'd6}); send_byte(8'h01);
    // system reset cancels control change; next data is an orphan
    send_byte(8'hB2); send_byte(mmp_pkg::ST_SYS_RESET); send_byte(8'h05);
    // one-byte kinds, then a two-byte pitch bend
    send_byte({mmp_pkg::KIND_PROGRAM, 4'h3}); send_byte(8'h7F);
    send_byte({mmp_pkg::KIND_PRESSURE, 4'h4}); send_byte(8'h00);
    send_byte(8'hE5); send_byte(8'h7F); send_byte(8'h7F);
    // SysEx with a channel status in the payload
    send_byte(mmp_pkg::ST_SYSEX_START); send_byte(8'h91); send_byte(8'h12);
    send_byte(mmp_pkg::ST_SYSEX_END);
    // stray end of SysEx, another system common byte, orphan
    send_byte(mmp_pkg::ST_SYSEX_END); send_byte({mmp_pkg::KIND_SYSTEM, 4'h1});
    send_byte(8'h33);

    while (bytes_sent < N_ITEMS) begin
      if ($urandom_range(0, 5) == 0) steady = ~steady;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed voice run with running status
        status = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
        len    = (status[7:4] == mmp_pkg::KIND_PROGRAM ||
                  status[7:4] == mmp_pkg::KIND_PRESSURE) ?
                 mmp_pkg::LEN_ONE : mmp_pkg::LEN_TWO;
        send_byte(status);
        n_msgs = $urandom_range(1, 6);
        for (int m = 0; m < n_msgs; m++) begin
          for (int d = 0; d < len; d++) begin
            if ($urandom_range(0, 7) == 0)
              send_byte({mmp_pkg::RT_PREFIX, 3'($urandom_range(0, 6))});
            send_byte(rand_data());
          end
        end
        // sometimes break the run after one more data byte
        if ($urandom_range(0, 9) == 0) begin
          send_byte(rand_data());
          case ($urandom_range(0, 2))
            0:       send_byte(mmp_pkg::ST_SYS_RESET);
            1:       send_byte({mmp_pkg::KIND_SYSTEM, 4'($urandom_range(1, 6))});
            default: send_byte(mmp_pkg::ST_SYSEX_END);
          endcase
          send_byte(rand_data());
        end
      end else if (pick < 82) begin
        // SysEx block with arbitrary payload
        send_byte(mmp_pkg::ST_SYSEX_START);
        n_bytes = $urandom_range(0, 8);
        for (int k = 0; k < n_bytes; k++) begin
          if ($urandom_range(0, 5) == 0)
            send_byte({mmp_pkg::RT_PREFIX, 3'($urandom_range(0, 7))});
          else send_byte(8'($urandom_range(0, 8'hEF)));
        end
        send_byte(($urandom_range(0, 4) == 0) ?
                  {mmp_pkg::KIND_SYSTEM, 4'($urandom_range(1, 6))} :
                  mmp_pkg::ST_SYSEX_END);
      end else begin
        // noise
        n_bytes = $urandom_range(1, 4);
        for (int k = 0; k < n_bytes; k++) send_byte(8'($urandom_range(0, 255)));
      end
    end

    // drop valid at the edge that took the last byte
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
